/* src/lsd_pkg.sv */
package lsd_pkg;

   // Decoded value width; the result field is always VALUE_W wide.
   localparam int VALUE_BITS = 64;
   localparam int VALUE_W    = 64;
   localparam int COUNT_W    = 8;
   localparam int GROUP_BITS = 7;
   localparam int SHIFT_W    = $clog2(VALUE_BITS + 1);
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [6:0]         GROUP_MASK = 7'h7f;
   // Bits of the result above the decoded width, used for sign fill.
   localparam logic [VALUE_W-1:0] HI_FILL    = ~VALUE_W'({VALUE_BITS{1'b1}});

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TRUNC    = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   // One classified input byte as it travels from front to back.
   typedef struct packed {
      logic [6:0] slice;
      logic       more;
      logic       sgn;
      logic       last;
   } item_type;

endpackage

/* src/lsd_front.sv */
module lsd_front
   import lsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_sgn,
   input  logic       in_last,
   output logic       push,
   input  logic       q_ready,
   output item_type   push_item
);

   logic     stg_valid_ff;
   logic     stg_valid_in;
   item_type stg_item_ff;
   item_type stg_item_in;
   logic     take;

   assign in_ready = !stg_valid_ff || q_ready;
   assign take     = in_valid && in_ready;
   assign push     = stg_valid_ff && q_ready;
   assign push_item = stg_item_ff;

   always_comb begin
      stg_valid_in = take || (stg_valid_ff && !q_ready);
      stg_item_in  = stg_item_ff;
      if (take) begin
         stg_item_in.slice = in_byte[6:0] & GROUP_MASK;
         stg_item_in.more  = in_byte[7];
         stg_item_in.sgn   = in_sgn;
         stg_item_in.last  = in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      stg_item_ff <= stg_item_in;
   end

endmodule

/* src/lsd_queue.sv */
module lsd_queue
   import lsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     push_ready,
   input  item_type push_item,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   item_type               mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]     count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = count_ff != Q_CNT_W'(Q_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/lsd_back.sv */
module lsd_back
   import lsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [VALUE_W-1:0] out_value,
   output logic [COUNT_W-1:0] out_count,
   output status_type         out_status
);

   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [SHIFT_W-1:0]    shift_ff, shift_in;
   logic                  skip_ff, skip_in;
   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]    out_value_ff, out_value_in;
   logic [COUNT_W-1:0]    out_count_ff, out_count_in;
   status_type            out_status_ff, out_status_in;

   logic                  in_range;
   logic [SHIFT_W-1:0]    rem;
   logic [2:0]            rem3;
   logic [2:0]            k;
   logic [6:0]            fill;
   logic [6:0]            hi;
   logic                  ovf;
   logic [VALUE_BITS-1:0] acc_add;
   logic [SHIFT_W:0]      shift_sum;
   logic                  sum_ge;
   logic [VALUE_BITS-1:0] lo_fill;
   logic [VALUE_BITS-1:0] v_low;
   logic [VALUE_W-1:0]    v_full;
   logic [COUNT_W-1:0]    cnt_inc;

   assign pop = q_valid && (!out_valid_ff || out_ready);

   // Overflow check on the group about to be placed at shift_ff.
   always_comb begin
      in_range = shift_ff < SHIFT_W'(VALUE_BITS);
      rem      = SHIFT_W'(VALUE_BITS) - shift_ff;
      rem3     = rem[2:0];
      k        = rem3 - 3'd1;
      fill     = (q_item.sgn && acc_ff[VALUE_BITS-1]) ? GROUP_MASK : 7'h00;
      hi       = q_item.slice >> k;
      if (!in_range) begin
         ovf = q_item.slice != fill;
      end else if (rem >= SHIFT_W'(GROUP_BITS)) begin
         ovf = 1'b0;
      end else if (!q_item.sgn) begin
         ovf = (q_item.slice >> rem3) != 7'h00;
      end else begin
         ovf = (hi != 7'h00) && (hi != (GROUP_MASK >> k));
      end
   end

   // Accumulate and build the sign-extended result.
   always_comb begin
      acc_add   = in_range ? (acc_ff | (VALUE_BITS'(q_item.slice) << shift_ff)) : acc_ff;
      shift_sum = {1'b0, shift_ff} + (SHIFT_W + 1)'(GROUP_BITS);
      sum_ge    = shift_sum >= (SHIFT_W + 1)'(VALUE_BITS);
      lo_fill   = {VALUE_BITS{1'b1}} << shift_sum;
      v_low     = acc_add;
      if (q_item.sgn && !sum_ge && q_item.slice[6]) begin
         v_low = acc_add | lo_fill;
      end
      v_full = VALUE_W'(v_low);
      if (q_item.sgn && sum_ge && acc_add[VALUE_BITS-1]) begin
         v_full = v_full | HI_FILL;
      end
      cnt_inc = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
   end

   always_comb begin
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      shift_in      = shift_ff;
      skip_in       = skip_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_value_in  = out_value_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      if (pop) begin
         if (skip_ff) begin
            // Drop the tail of an overflowed encoding.
            skip_in = q_item.more && !q_item.last;
         end else if (ovf) begin
            out_valid_in  = 1'b1;
            out_value_in  = '0;
            out_count_in  = cnt_ff;
            out_status_in = ST_OVERFLOW;
            acc_in        = '0;
            cnt_in        = '0;
            shift_in      = '0;
            skip_in       = q_item.more && !q_item.last;
         end else if (q_item.more && q_item.last) begin
            out_valid_in  = 1'b1;
            out_value_in  = '0;
            out_count_in  = cnt_inc;
            out_status_in = ST_TRUNC;
            acc_in        = '0;
            cnt_in        = '0;
            shift_in      = '0;
         end else if (q_item.more) begin
            acc_in   = acc_add;
            cnt_in   = cnt_inc;
            shift_in = sum_ge ? SHIFT_W'(VALUE_BITS) : shift_sum[SHIFT_W-1:0];
         end else begin
            out_valid_in  = 1'b1;
            out_value_in  = v_full;
            out_count_in  = cnt_inc;
            out_status_in = ST_OK;
            acc_in        = '0;
            cnt_in        = '0;
            shift_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         shift_ff     <= '0;
         skip_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         shift_ff     <= shift_in;
         skip_ff      <= skip_in;
         out_valid_ff <= out_valid_in;
      end
      out_value_ff  <= out_value_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_value  = out_value_ff;
   assign out_count  = out_count_ff;
   assign out_status = out_status_ff;

endmodule

/* src/leb128_stream_decoder.sv */
// LEB128 stream decoder, one encoded byte per transaction.
// Input channel req_: tdata carries the byte (bit 7 = more bytes follow),
// tuser[0] selects signed decoding, tlast marks the last byte available.
// Result channel rsp_: tdata carries the value and the byte count, tuser
// the status (ok, truncated, overflow). A result leaves after the byte that
// ends a value, hits the buffer end mid-value, or overflows 64 bits; bytes
// after an overflow up to the end of that encoding are consumed silently.
// Throughput: one byte per cycle while rsp_tready stays high. On its way a
// byte passes the input stage, the 4-entry queue and the decode stage with
// its output register.
// The decode stage works out each accumulator update combinationally,
// which sets the one byte per cycle rate.
// When the receiver stalls, the output register holds its result and the
// queue fills; req_tready drops once the queue and input stage are full.
// Synchronous reset empties the queue, clears the accumulator, the byte
// count and the skip flag, and drops rsp_tvalid.
module leb128_stream_decoder
   import lsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,  // [7:0] data_byte
   input  logic [0:0]           req_tuser,  // [0] signed_mode
   input  logic                 req_tlast,  // buffer_end
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [VALUE_W+COUNT_W-1:0] rsp_tdata, // [63:0] value, [71:64] byte_count
   output logic [1:0]           rsp_tuser   // [1:0] status
);

   logic               push;
   logic               q_ready;
   item_type           push_item;
   logic               q_valid;
   item_type           q_item;
   logic               pop;
   logic [VALUE_W-1:0] value;
   logic [COUNT_W-1:0] byte_count;
   status_type         status;

   lsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_sgn    (req_tuser[0]),
      .in_last   (req_tlast),
      .push      (push),
      .q_ready   (q_ready),
      .push_item (push_item)
   );

   lsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (q_ready),
      .push_item  (push_item),
      .pop        (pop),
      .pop_valid  (q_valid),
      .pop_item   (q_item)
   );

   lsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (value),
      .out_count  (byte_count),
      .out_status (status)
   );

   assign rsp_tdata = {byte_count, value};
   assign rsp_tuser = status;

endmodule

/* src/lsd_checker.sv */
module lsd_checker
   import lsd_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [7:0]                   req_tdata,
   input logic [0:0]                   req_tuser,
   input logic                         req_tlast,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [VALUE_W+COUNT_W-1:0]   rsp_tdata,
   input logic [1:0]                   rsp_tuser
);

   // Hold a stalled result transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Reset drops any pending result.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Error results carry a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_TRUNC || rsp_tuser == ST_OVERFLOW)
         |-> rsp_tdata[VALUE_W-1:0] == '0)
      else $error("error result with nonzero value");

   // Every result has consumed at least one byte.
   a_count_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[VALUE_W+COUNT_W-1:VALUE_W] != '0)
      else $error("result with zero byte count");

endmodule

bind leb128_stream_decoder lsd_checker u_lsd_checker (.*);
